>>> src/owm_pkg.sv
// One-wire bus master: shared types, codes and slot timing tables.
// Used by owm_core and the top level.
`default_nettype none
package owm_pkg;

  localparam int TIMER_WIDTH    = 11;
  localparam int PRESCALE_WIDTH = 8;
  localparam int QUS_WIDTH      = 8;
  localparam int PC_CMP_W       = ((PRESCALE_WIDTH > QUS_WIDTH) ? PRESCALE_WIDTH : QUS_WIDTH) + 1;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUS = 1'b0,
    REG_OD  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    FN_RESET  = 3'd0,
    FN_WBIT   = 3'd1,
    FN_RBIT   = 3'd2,
    FN_WBYTE  = 3'd3,
    FN_RBYTE  = 3'd4,
    FN_PULLUP = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_SEG0 = 3'd1,
    PH_SEG1 = 3'd2,
    PH_SEG2 = 3'd3,
    PH_SEG3 = 3'd4
  } phase_t;

  // Delay selectors A..J
  typedef enum logic [3:0] {
    DLY_A = 4'd0, DLY_B = 4'd1, DLY_C = 4'd2, DLY_D = 4'd3, DLY_E = 4'd4,
    DLY_F = 4'd5, DLY_G = 4'd6, DLY_H = 4'd7, DLY_I = 4'd8, DLY_J = 4'd9
  } dly_t;

  typedef struct packed {
    logic            start_req;
    logic [2:0]      func;
    logic [7:0]      data;
    logic            line_in;
  } owm_item_t;

  typedef struct packed {
    logic            drive_low;
    logic            strong_pullup;
    logic            busy_res;
    logic            done_res;
    logic            presence;
    logic [7:0]      read_data;
  } owm_res_t;

  typedef struct packed {
    logic [QUS_WIDTH-1:0] quarter_us_cycles;
    logic                 overdrive;
  } owm_cfg_t;

  // Which delay a segment uses; one is the current write bit.
  function automatic dly_t seg_delay(input func_t cmd, input logic [1:0] seg, input logic one);
    dly_t d;
    d = DLY_A;
    case (cmd)
      FN_RESET: begin
        case (seg)
          2'd0:    d = DLY_G;
          2'd1:    d = DLY_H;
          2'd2:    d = DLY_I;
          default: d = DLY_J;
        endcase
      end
      FN_WBIT, FN_WBYTE: begin
        if (seg == 2'd0) d = one ? DLY_A : DLY_C;
        else             d = one ? DLY_B : DLY_D;
      end
      default: begin
        case (seg)
          2'd0:    d = DLY_A;
          2'd1:    d = DLY_E;
          default: d = DLY_F;
        endcase
      end
    endcase
    return d;
  endfunction

  // Segment length in quarter microseconds.
  function automatic logic [TIMER_WIDTH-1:0] slot_delay(input logic od, input dly_t d);
    logic [TIMER_WIDTH-1:0] v;
    v = '0;
    if (!od) begin
      case (d)
        DLY_A:   v = TIMER_WIDTH'(24);
        DLY_B:   v = TIMER_WIDTH'(256);
        DLY_C:   v = TIMER_WIDTH'(240);
        DLY_D:   v = TIMER_WIDTH'(40);
        DLY_E:   v = TIMER_WIDTH'(36);
        DLY_F:   v = TIMER_WIDTH'(220);
        DLY_G:   v = TIMER_WIDTH'(0);
        DLY_H:   v = TIMER_WIDTH'(1920);
        DLY_I:   v = TIMER_WIDTH'(280);
        DLY_J:   v = TIMER_WIDTH'(1640);
        default: v = '0;
      endcase
    end else begin
      case (d)
        DLY_A:   v = TIMER_WIDTH'(6);
        DLY_B:   v = TIMER_WIDTH'(30);
        DLY_C:   v = TIMER_WIDTH'(30);
        DLY_D:   v = TIMER_WIDTH'(10);
        DLY_E:   v = TIMER_WIDTH'(3);
        DLY_F:   v = TIMER_WIDTH'(28);
        DLY_G:   v = TIMER_WIDTH'(10);
        DLY_H:   v = TIMER_WIDTH'(280);
        DLY_I:   v = TIMER_WIDTH'(34);
        DLY_J:   v = TIMER_WIDTH'(160);
        default: v = '0;
      endcase
    end
    return v;
  endfunction

endpackage
`default_nettype wire

>>> src/owm_if.sv
// Valid/ready channel interfaces for the one-wire bus master.
`default_nettype none
interface owm_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [2:0] func;
  logic [7:0] data;
  logic       line_in;

  modport source (output valid, start_req, func, data, line_in, input ready);
  modport sink   (input valid, start_req, func, data, line_in, output ready);
endinterface

interface owm_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       strong_pullup;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] read_data;

  modport source (output valid, drive_low, strong_pullup, busy_res, done_res, presence,
                  read_data, input ready);
  modport sink   (input valid, drive_low, strong_pullup, busy_res, done_res, presence,
                  read_data, output ready);
endinterface
`default_nettype wire

>>> src/one_wire_bus_master.sv
// One-wire bus master top level: configuration registers, tick channel and
// result register. Depends on owm_pkg, owm_if and owm_core.
//
// Every input beat is one tick of the bus timing engine and yields exactly one
// result beat holding the line controls and status after that tick. A beat is
// accepted every clock cycle while the result register is empty or being
// drained in the same cycle; the result is held in a single output register.
// Slot lengths come from the standard or overdrive table in quarter
// microseconds, with quarter_us_cycles ticks per unit set by the prescaler.
`default_nettype none
module one_wire_bus_master (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  owm_in_if.sink                                 in_ch,
  owm_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [owm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [owm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  owm_pkg::owm_cfg_t  cfg_r;
  owm_pkg::owm_item_t item;
  owm_pkg::owm_res_t  res, res_r;
  logic               out_valid_r;
  logic               accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.quarter_us_cycles <= owm_pkg::QUS_WIDTH'(4);
      cfg_r.overdrive         <= 1'b0;
    end else if (cfg_we) begin
      case (owm_pkg::cfg_reg_t'(cfg_index))
        owm_pkg::REG_QUS: cfg_r.quarter_us_cycles <= cfg_data[owm_pkg::QUS_WIDTH-1:0];
        owm_pkg::REG_OD:  cfg_r.overdrive         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign item.start_req = in_ch.start_req;
  assign item.func      = in_ch.func;
  assign item.data      = in_ch.data;
  assign item.line_in   = in_ch.line_in;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  owm_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (accept),
    .item  (item),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res_r <= res;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.drive_low     = res_r.drive_low;
  assign out_ch.strong_pullup = res_r.strong_pullup;
  assign out_ch.busy_res      = res_r.busy_res;
  assign out_ch.done_res      = res_r.done_res;
  assign out_ch.presence      = res_r.presence;
  assign out_ch.read_data     = res_r.read_data;

endmodule
`default_nettype wire

>>> src/owm_core.sv
// Slot timing engine: prescaler, segment sequencer and bit shifter.
// Advances one tick per accepted beat. Depends on owm_pkg.
`default_nettype none
module owm_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire owm_pkg::owm_item_t item,
  input  wire owm_pkg::owm_cfg_t  cfg,
  output owm_pkg::owm_res_t       res
);

  owm_pkg::phase_t                      phase_r, phase_nxt;
  logic [owm_pkg::TIMER_WIDTH-1:0]      slot_timer_r, slot_timer_nxt;
  logic [owm_pkg::PRESCALE_WIDTH-1:0]   prescale_r, prescale_nxt;
  logic [7:0]                           shift_r, shift_nxt;
  logic [3:0]                           bits_left_r, bits_left_nxt;
  owm_pkg::func_t                       command_r, command_nxt;
  logic                                 presence_r, presence_nxt;
  logic                                 pullup_r, pullup_nxt;

  logic                                 done;
  logic                                 unit;
  logic [owm_pkg::PC_CMP_W-1:0]         pc_inc, q_eff;
  logic [owm_pkg::TIMER_WIDTH-1:0]      timer_dec, d0;
  logic [1:0]                           seg, seg_next, nseg_last;
  logic                                 is_write, sample;
  owm_pkg::func_t                       start_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= owm_pkg::PH_IDLE;
      slot_timer_r <= '0;
      prescale_r   <= '0;
      shift_r      <= '0;
      bits_left_r  <= '0;
      command_r    <= owm_pkg::FN_RESET;
      presence_r   <= 1'b0;
      pullup_r     <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      slot_timer_r <= slot_timer_nxt;
      prescale_r   <= prescale_nxt;
      shift_r      <= shift_nxt;
      bits_left_r  <= bits_left_nxt;
      command_r    <= command_nxt;
      presence_r   <= presence_nxt;
      pullup_r     <= pullup_nxt;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    slot_timer_nxt = slot_timer_r;
    prescale_nxt   = prescale_r;
    shift_nxt      = shift_r;
    bits_left_nxt  = bits_left_r;
    command_nxt    = command_r;
    presence_nxt   = presence_r;
    pullup_nxt     = pullup_r;
    done           = 1'b0;

    // quarter_us_cycles of zero counts as one
    q_eff  = (cfg.quarter_us_cycles == '0) ? owm_pkg::PC_CMP_W'(1)
                                           : owm_pkg::PC_CMP_W'(cfg.quarter_us_cycles);
    pc_inc = owm_pkg::PC_CMP_W'(prescale_r) + owm_pkg::PC_CMP_W'(1);
    unit   = (pc_inc >= q_eff) || (prescale_r == '1);
    timer_dec = (unit && slot_timer_r != '0) ? slot_timer_r - 1'b1 : slot_timer_r;

    seg       = 2'(phase_r - 3'd1);
    is_write  = (command_r == owm_pkg::FN_WBIT) || (command_r == owm_pkg::FN_WBYTE);
    sample    = (command_r == owm_pkg::FN_RESET) ? (seg == 2'd2) : (!is_write && seg == 2'd1);
    nseg_last = (command_r == owm_pkg::FN_RESET) ? 2'd3 : (is_write ? 2'd1 : 2'd2);
    seg_next  = seg + 2'd1;
    start_cmd = owm_pkg::func_t'(item.func);
    d0        = '0;

    if (phase_r != owm_pkg::PH_IDLE) begin
      prescale_nxt   = unit ? '0 : prescale_r + 1'b1;
      slot_timer_nxt = timer_dec;
      if (timer_dec == '0) begin
        if (sample) begin
          if (command_r == owm_pkg::FN_RESET) presence_nxt = !item.line_in;
          else                                shift_nxt    = {item.line_in, shift_r[7:1]};
        end
        if (seg == nseg_last) begin
          if (is_write) shift_nxt = {shift_r[0], shift_r[7:1]};
          bits_left_nxt = bits_left_r - 4'd1;
          seg_next      = 2'd0;
        end
        if (seg == nseg_last && bits_left_nxt == 4'd0) begin
          phase_nxt      = owm_pkg::PH_IDLE;
          slot_timer_nxt = '0;
          done           = 1'b1;
        end else begin
          phase_nxt      = owm_pkg::phase_t'({1'b0, seg_next} + 3'd1);
          slot_timer_nxt = owm_pkg::slot_delay(cfg.overdrive,
                             owm_pkg::seg_delay(command_r, seg_next, shift_nxt[0]));
        end
      end
    end else if (item.start_req && item.func <= owm_pkg::FN_PULLUP) begin
      pullup_nxt = 1'b0;
      if (start_cmd == owm_pkg::FN_PULLUP) begin
        pullup_nxt = 1'b1;
        done       = 1'b1;
      end else begin
        command_nxt   = start_cmd;
        shift_nxt     = item.data;
        bits_left_nxt = (item.func >= owm_pkg::FN_WBYTE) ? 4'd8 : 4'd1;
        prescale_nxt  = '0;
        d0 = owm_pkg::slot_delay(cfg.overdrive,
               owm_pkg::seg_delay(start_cmd, 2'd0, item.data[0]));
        // a zero-length first segment ends at once; it never samples
        if (d0 == '0) begin
          phase_nxt      = owm_pkg::PH_SEG1;
          slot_timer_nxt = owm_pkg::slot_delay(cfg.overdrive,
                             owm_pkg::seg_delay(start_cmd, 2'd1, item.data[0]));
        end else begin
          phase_nxt      = owm_pkg::PH_SEG0;
          slot_timer_nxt = d0;
        end
      end
    end

    res.drive_low     = (phase_nxt != owm_pkg::PH_IDLE) &&
                        ((command_nxt == owm_pkg::FN_RESET) ? (phase_nxt == owm_pkg::PH_SEG1)
                                                            : (phase_nxt == owm_pkg::PH_SEG0));
    res.strong_pullup = (phase_nxt == owm_pkg::PH_IDLE) && pullup_nxt;
    res.busy_res      = (phase_nxt != owm_pkg::PH_IDLE);
    res.done_res      = done;
    res.presence      = presence_nxt;
    res.read_data     = shift_nxt;
  end

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.done_res |=> phase_r == owm_pkg::PH_IDLE)
    else $error("command completed but sequencer still running");

  a_busy_no_pullup: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != owm_pkg::PH_IDLE |-> !pullup_r)
    else $error("strong pullup flag set during a slot");

  a_busy_bits: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != owm_pkg::PH_IDLE |-> bits_left_r != 4'd0 && slot_timer_r != '0)
    else $error("running with no bits left or an expired timer");

  a_seg3_reset: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == owm_pkg::PH_SEG3 |-> command_r == owm_pkg::FN_RESET)
    else $error("fourth segment outside a reset slot");

endmodule
`default_nettype wire
